[hdl/cpr_pkg.sv]
package cpr_pkg;

  // Fixed field widths of the request and response transactions
  localparam int FRAME_W    = 6;
  localparam int FRAME_SPAN = 2 ** FRAME_W;
  localparam int OPCODE_W   = 2;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_ACCESS = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SETEV  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_EVICT  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic do_access;  // set reference bit of the request frame
    logic do_setev;   // write evictable bit of the request frame
    logic step;       // examine the frame under the hand and advance
    logic load_out;   // capture the evict response into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic any_evict;  // at least one frame is evictable
    logic hit;        // frame under the hand is evictable and unreferenced
  } status_t;

endpackage

[hdl/cpr_req_if.sv]
interface cpr_req_if;
  logic                          valid;
  logic                          ready;
  logic [cpr_pkg::OPCODE_W-1:0]  opcode;
  logic [cpr_pkg::FRAME_W-1:0]   frame;
  logic                          make_evictable;

  modport source (output valid, output opcode, output frame, output make_evictable,
                  input ready);
  modport sink   (input valid, input opcode, input frame, input make_evictable,
                  output ready);
endinterface

[hdl/cpr_rsp_if.sv]
interface cpr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cpr_pkg::FRAME_W-1:0]  victim;
  logic                         found;

  modport source (output valid, output victim, output found, input ready);
  modport sink   (input valid, input victim, input found, output ready);
endinterface

[hdl/cpr_dp.sv]
module cpr_dp #(
  parameter int FRAMES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cpr_pkg::cmd_t                cmd,
  input  logic [cpr_pkg::FRAME_W-1:0]  frame,
  input  logic                         make_evictable,
  output cpr_pkg::status_t             status,
  output logic [cpr_pkg::FRAME_W-1:0]  victim,
  output logic                         found
);

  // Frames above the request index range are never written: they stay
  // evictable and unreferenced, so only the addressable ones are stored.
  localparam int STORE = (FRAMES < cpr_pkg::FRAME_SPAN) ? FRAMES : cpr_pkg::FRAME_SPAN;
  localparam int SW    = $clog2(STORE);
  localparam int HW    = $clog2(FRAMES);
  localparam int CW    = $clog2(STORE + 1);
  localparam logic [HW-1:0] HAND_LAST = HW'(FRAMES - 1);
  localparam bit ALWAYS_ANY = (FRAMES > cpr_pkg::FRAME_SPAN);

  logic [STORE-1:0]            ref_r, ref_nxt;
  logic [STORE-1:0]            ok_r, ok_nxt;
  logic [HW-1:0]               hand_r, hand_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [cpr_pkg::FRAME_W-1:0] victim_r, victim_nxt;
  logic                        found_r, found_nxt;

  logic          frame_ok;
  logic [SW-1:0] wr_idx;
  logic          hand_in;
  logic [SW-1:0] hand_idx;
  logic          cur_ok;
  logic          cur_ref;
  logic          any_evict;

  // Request frame decode
  assign frame_ok = (32'(frame) < FRAMES);
  assign wr_idx   = frame[SW-1:0];

  // Frame under the hand
  assign hand_in  = (32'(hand_r) < STORE);
  assign hand_idx = hand_r[SW-1:0];
  assign cur_ok   = hand_in ? ok_r[hand_idx]  : 1'b1;
  assign cur_ref  = hand_in ? ref_r[hand_idx] : 1'b0;

  assign any_evict = ALWAYS_ANY ? 1'b1 : (cnt_r != '0);

  assign status.any_evict = any_evict;
  assign status.hit       = cur_ok & ~cur_ref;

  // Next state
  always_comb begin
    ref_nxt    = ref_r;
    ok_nxt     = ok_r;
    hand_nxt   = hand_r;
    cnt_nxt    = cnt_r;
    victim_nxt = victim_r;
    found_nxt  = found_r;

    if (cmd.do_access && frame_ok) begin
      ref_nxt[wr_idx] = 1'b1;
    end

    if (cmd.do_setev && frame_ok) begin
      ok_nxt[wr_idx] = make_evictable;
      // keep the evictable count in step with the bit change
      if (ok_r[wr_idx] != make_evictable) begin
        cnt_nxt = make_evictable ? cnt_r + CW'(1) : cnt_r - CW'(1);
      end
    end

    // one frame per step: second chance clears the reference bit
    if (cmd.step) begin
      if (hand_in && cur_ok && cur_ref) begin
        ref_nxt[hand_idx] = 1'b0;
      end
      hand_nxt = (hand_r == HAND_LAST) ? '0 : hand_r + HW'(1);
    end

    if (cmd.load_out) begin
      victim_nxt = any_evict ? cpr_pkg::FRAME_W'(hand_r) : '0;
      found_nxt  = any_evict;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= '0;
      ok_r   <= '1;
      hand_r <= '0;
      cnt_r  <= CW'(STORE);
    end else begin
      ref_r  <= ref_nxt;
      ok_r   <= ok_nxt;
      hand_r <= hand_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    victim_r <= victim_nxt;
    found_r  <= found_nxt;
  end

  assign victim = victim_r;
  assign found  = found_r;

endmodule

[hdl/cpr_ctrl.sv]
module cpr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [cpr_pkg::OPCODE_W-1:0]  opcode,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  cpr_pkg::status_t              status,
  output cpr_pkg::cmd_t                 cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  // output register can take a new response this cycle
  assign out_free = ~out_valid_r | out_ready;

  // Sequencing
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (opcode == cpr_pkg::OP_ACCESS) begin
            cmd.do_access = 1'b1;
          end else if (opcode == cpr_pkg::OP_SETEV) begin
            cmd.do_setev = 1'b1;
          end else if (opcode == cpr_pkg::OP_EVICT) begin
            state_nxt = ST_WALK;
          end else begin
            // unused opcode: dropped
          end
        end
      end
      ST_WALK: begin
        priority if (!status.any_evict) begin
          // nothing evictable: answer not found, state untouched
          if (out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (status.hit) begin
          // victim under the hand: wait for the output register
          if (out_free) begin
            cmd.load_out = 1'b1;
            cmd.step     = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid
  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/clock_page_replacer_core.sv]
// Clock (second-chance) page replacer.
// in_ch carries requests: opcode access sets a frame's reference bit,
// set-evictable writes its evictable bit, evict asks for a victim.
// Access and set-evictable with a frame at or above FRAMES, and the unused
// opcode, are dropped and give no response. Only evict answers, on out_ch,
// with victim and found (found=0, victim=0 when no frame is evictable).
// An evict is accepted, then the hand walks the frame bits one frame per
// cycle until it finds a victim; the response is loaded into the output
// register once the victim is found and the register is free.
// in_ch is ready whenever no evict walk is in progress, also while a
// response waits in the output register; a walk that finds its victim while
// out_ch is stalled holds there until the register frees.
// Reset (rst_n low, synchronous) clears all reference bits, marks all frames
// evictable, puts the hand at frame 0 and empties the output register.
module clock_page_replacer_core #(
  parameter int FRAMES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  cpr_req_if.sink  in_ch,
  cpr_rsp_if.source out_ch
);

  cpr_pkg::cmd_t    cmd;
  cpr_pkg::status_t status;

  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .opcode    (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cpr_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .frame          (in_ch.frame),
    .make_evictable (in_ch.make_evictable),
    .status         (status),
    .victim         (out_ch.victim),
    .found          (out_ch.found)
  );

endmodule
